// ===== hw/rtl/mde_pkg.sv =====
`timescale 1ns / 1ps

package mde_pkg;

    // Mesh ports of this node; PORTS itself stands for "no parent" (root).
    localparam int PORTS     = 6;
    localparam int PORT_W    = $clog2(PORTS + 1);
    localparam int CMP_W     = 4;
    localparam int READY_W   = 6;
    localparam int NUM_W     = 8;
    localparam int MIN_TOTAL = 3;
    localparam logic [NUM_W-1:0] MAX_NUMBER_RST = 8'd63;

    typedef enum logic [1:0] {
        MODE_CLICK = 2'd0,
        MODE_REQ   = 2'd1,
        MODE_RESP  = 2'd2,
        MODE_BCAST = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_REQ   = 2'd0,
        KIND_RESP  = 2'd1,
        KIND_BCAST = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_PENDING  = 3'd1,
        PH_ASSIGNED = 3'd2,
        PH_DONE     = 3'd3,
        PH_FAILED   = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EVAL = 2'd1,
        ST_SCAN = 2'd2,
        ST_EMIT = 2'd3
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic eval;
        logic scan;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic scan_needed;
        logic scan_stop;
        logic out_free;
    } sts_t;

    // A send on port p succeeds: the port exists and its ready bit is set.
    function automatic logic port_ok(input logic [READY_W-1:0] ready,
                                     input logic [CMP_W-1:0] p);
        logic ok;
        ok = 1'b0;
        if ((p < CMP_W'(PORTS)) && (p < CMP_W'(READY_W)))
            ok = ready[p[2:0]];
        return ok;
    endfunction

endpackage

// ===== hw/rtl/mde_ctrl.sv =====
`timescale 1ns / 1ps

module mde_ctrl (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  mde_pkg::sts_t sts,
    output mde_pkg::cmd_t cmd
);

    mde_pkg::ctrl_state_t state_reg;
    mde_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mde_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mde_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = mde_pkg::ST_EVAL;
            end
            mde_pkg::ST_EVAL:
            begin
                state_next = sts.scan_needed ? mde_pkg::ST_SCAN : mde_pkg::ST_EMIT;
            end
            mde_pkg::ST_SCAN:
            begin
                if (sts.scan_stop)
                    state_next = mde_pkg::ST_EMIT;
            end
            mde_pkg::ST_EMIT:
            begin
                if (sts.out_free)
                    state_next = mde_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mde_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready     = (state_reg == mde_pkg::ST_IDLE);
        cmd.capture  = (state_reg == mde_pkg::ST_IDLE) && s_tvalid;
        cmd.eval     = (state_reg == mde_pkg::ST_EVAL);
        cmd.scan     = (state_reg == mde_pkg::ST_SCAN);
        cmd.load_out = (state_reg == mde_pkg::ST_EMIT) && sts.out_free;
    end

    // At most one datapath command per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.eval, cmd.scan, cmd.load_out}))
        else $error("more than one datapath command");

    // An item always finishes by loading the output register before the next capture.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> state_reg == mde_pkg::ST_IDLE)
        else $error("output load did not return to idle");

    // An accepted item is decoded in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == mde_pkg::ST_EVAL)
        else $error("accepted item not decoded");

endmodule

// ===== hw/rtl/mde_dp.sv =====
`timescale 1ns / 1ps

module mde_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mde_pkg::cmd_t                 cmd,
    output mde_pkg::sts_t                 sts,
    input  logic                          cfg_we,
    input  logic [mde_pkg::NUM_W-1:0]     cfg_wdata,
    input  logic [1:0]                    in_mode,
    input  logic [2:0]                    in_face,
    input  logic [mde_pkg::NUM_W-1:0]     in_payload,
    input  logic [mde_pkg::READY_W-1:0]   in_ports_ready,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic                          out_send_valid,
    output logic [1:0]                    out_send_kind,
    output logic [2:0]                    out_send_port,
    output logic [mde_pkg::NUM_W-1:0]     out_send_number,
    output logic [2:0]                    out_phase_now,
    output logic [mde_pkg::NUM_W-1:0]     out_own_number,
    output logic [mde_pkg::NUM_W-1:0]     out_node_total
);

    localparam int PW = mde_pkg::PORT_W;
    localparam int NW = mde_pkg::NUM_W;
    localparam int CW = mde_pkg::CMP_W;

    // captured item
    mde_pkg::mode_t              mode_reg, mode_next;
    logic [2:0]                  face_reg, face_next;
    logic [NW-1:0]               pay_reg, pay_next;
    logic [mde_pkg::READY_W-1:0] rdy_reg, rdy_next;

    // node state
    logic [NW-1:0]   max_num_reg, max_num_next;
    mde_pkg::phase_t phase_reg, phase_next;
    logic [NW-1:0]   my_num_reg, my_num_next;
    logic [NW-1:0]   total_reg, total_next;
    logic [PW-1:0]   parent_reg, parent_next;
    logic [PW-1:0]   scan_reg, scan_next;
    logic [NW-1:0]   next_num_reg, next_num_next;

    // message under construction
    logic            snd_valid_reg, snd_valid_next;
    mde_pkg::kind_t  snd_kind_reg, snd_kind_next;
    logic [2:0]      snd_port_reg, snd_port_next;
    logic [NW-1:0]   snd_num_reg, snd_num_next;

    // output register
    logic            out_valid_reg, out_valid_next;
    logic            o_valid_reg, o_valid_next;
    mde_pkg::kind_t  o_kind_reg, o_kind_next;
    logic [2:0]      o_port_reg, o_port_next;
    logic [NW-1:0]   o_num_reg, o_num_next;
    mde_pkg::phase_t o_phase_reg, o_phase_next;
    logic [NW-1:0]   o_own_reg, o_own_next;
    logic [NW-1:0]   o_total_reg, o_total_next;

    logic            scan_past_end;
    logic            scan_hit;
    logic [NW-1:0]   highest;
    logic [NW-1:0]   start;
    logic            face_exists;

    always_comb
    begin
        scan_past_end = (CW'(scan_reg) >= CW'(mde_pkg::PORTS));
        scan_hit      = (scan_reg != parent_reg) &&
                        mde_pkg::port_ok(rdy_reg, CW'(scan_reg));
        highest       = next_num_reg - NW'(1);
        face_exists   = ({1'b0, face_reg} < CW'(mde_pkg::PORTS));
        start         = (mode_reg == mde_pkg::MODE_REQ) ? pay_reg : '0;

        sts.scan_needed = 1'b0;
        sts.scan_stop   = scan_past_end || scan_hit;
        sts.out_free    = !out_valid_reg || m_tready;

        mode_next      = mode_reg;
        face_next      = face_reg;
        pay_next       = pay_reg;
        rdy_next       = rdy_reg;
        max_num_next   = cfg_we ? cfg_wdata : max_num_reg;
        phase_next     = phase_reg;
        my_num_next    = my_num_reg;
        total_next     = total_reg;
        parent_next    = parent_reg;
        scan_next      = scan_reg;
        next_num_next  = next_num_reg;
        snd_valid_next = snd_valid_reg;
        snd_kind_next  = snd_kind_reg;
        snd_port_next  = snd_port_reg;
        snd_num_next   = snd_num_reg;

        if (cmd.capture)
        begin
            mode_next      = mde_pkg::mode_t'(in_mode);
            face_next      = in_face;
            pay_next       = in_payload;
            rdy_next       = in_ports_ready;
            snd_valid_next = 1'b0;
            snd_kind_next  = mde_pkg::KIND_REQ;
            snd_port_next  = '0;
            snd_num_next   = '0;
        end

        if (cmd.eval)
        begin
            unique case (phase_reg)
                mde_pkg::PH_IDLE:
                begin
                    if (mode_reg == mde_pkg::MODE_CLICK || mode_reg == mde_pkg::MODE_REQ)
                    begin
                        parent_next = PW'(mde_pkg::PORTS);
                        if (mode_reg == mde_pkg::MODE_REQ && !face_exists)
                            phase_next = mde_pkg::PH_FAILED;
                        else if (start > max_num_reg)
                        begin
                            if (mode_reg == mde_pkg::MODE_REQ)
                                parent_next = PW'(face_reg);
                            phase_next = mde_pkg::PH_FAILED;
                        end
                        else
                        begin
                            if (mode_reg == mde_pkg::MODE_REQ)
                                parent_next = PW'(face_reg);
                            my_num_next     = start;
                            scan_next       = '0;
                            next_num_next   = start + NW'(1);
                            sts.scan_needed = 1'b1;
                        end
                    end
                end
                mde_pkg::PH_PENDING:
                begin
                    if (mode_reg == mde_pkg::MODE_REQ)
                    begin
                        if (mde_pkg::port_ok(rdy_reg, CW'(face_reg)))
                        begin
                            snd_valid_next = 1'b1;
                            snd_kind_next  = mde_pkg::KIND_RESP;
                            snd_port_next  = face_reg;
                        end
                    end
                    else if (mode_reg == mde_pkg::MODE_RESP)
                    begin
                        if (CW'(face_reg) != CW'(scan_reg))
                            phase_next = mde_pkg::PH_FAILED;
                        else
                        begin
                            scan_next = scan_reg + PW'(1);
                            if (pay_reg >= next_num_reg)
                                next_num_next = pay_reg + NW'(1);
                            sts.scan_needed = 1'b1;
                        end
                    end
                end
                mde_pkg::PH_ASSIGNED:
                begin
                    if (mode_reg == mde_pkg::MODE_REQ)
                    begin
                        if (mde_pkg::port_ok(rdy_reg, CW'(face_reg)))
                        begin
                            snd_valid_next = 1'b1;
                            snd_kind_next  = mde_pkg::KIND_RESP;
                            snd_port_next  = face_reg;
                        end
                    end
                    else if (mode_reg == mde_pkg::MODE_BCAST)
                    begin
                        total_next = pay_reg;
                        phase_next = mde_pkg::PH_DONE;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.scan)
        begin
            priority if (scan_past_end)
            begin
                // no port left: hand the highest number back or finish at the root, else fail
                if (CW'(parent_reg) < CW'(mde_pkg::PORTS))
                begin
                    if (!mde_pkg::port_ok(rdy_reg, CW'(parent_reg)))
                        phase_next = mde_pkg::PH_FAILED;
                    else
                    begin
                        snd_valid_next = 1'b1;
                        snd_kind_next  = mde_pkg::KIND_RESP;
                        snd_port_next  = 3'(parent_reg);
                        snd_num_next   = highest;
                        phase_next     = mde_pkg::PH_ASSIGNED;
                    end
                end
                else if (highest < NW'(mde_pkg::MIN_TOTAL))
                    phase_next = mde_pkg::PH_FAILED;
                else
                begin
                    total_next     = highest;
                    snd_valid_next = 1'b1;
                    snd_kind_next  = mde_pkg::KIND_BCAST;
                    snd_port_next  = '0;
                    snd_num_next   = highest;
                    phase_next     = mde_pkg::PH_DONE;
                end
            end
            else if (scan_hit)
            begin
                snd_valid_next = 1'b1;
                snd_kind_next  = mde_pkg::KIND_REQ;
                snd_port_next  = 3'(scan_reg);
                snd_num_next   = next_num_reg;
                phase_next     = mde_pkg::PH_PENDING;
            end
            else
                scan_next = scan_reg + PW'(1);
        end
    end

    always_comb
    begin
        o_valid_next = o_valid_reg;
        o_kind_next  = o_kind_reg;
        o_port_next  = o_port_reg;
        o_num_next   = o_num_reg;
        o_phase_next = o_phase_reg;
        o_own_next   = o_own_reg;
        o_total_next = o_total_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            o_valid_next   = snd_valid_reg;
            o_kind_next    = snd_kind_reg;
            o_port_next    = snd_port_reg;
            o_num_next     = snd_num_reg;
            o_phase_next   = phase_reg;
            o_own_next     = my_num_reg;
            o_total_next   = total_reg;
        end
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_num_reg   <= mde_pkg::MAX_NUMBER_RST;
            phase_reg     <= mde_pkg::PH_IDLE;
            my_num_reg    <= '0;
            total_reg     <= '0;
            parent_reg    <= PW'(mde_pkg::PORTS);
            scan_reg      <= '0;
            next_num_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            max_num_reg   <= max_num_next;
            phase_reg     <= phase_next;
            my_num_reg    <= my_num_next;
            total_reg     <= total_next;
            parent_reg    <= parent_next;
            scan_reg      <= scan_next;
            next_num_reg  <= next_num_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        face_reg      <= face_next;
        pay_reg       <= pay_next;
        rdy_reg       <= rdy_next;
        snd_valid_reg <= snd_valid_next;
        snd_kind_reg  <= snd_kind_next;
        snd_port_reg  <= snd_port_next;
        snd_num_reg   <= snd_num_next;
        o_valid_reg   <= o_valid_next;
        o_kind_reg    <= o_kind_next;
        o_port_reg    <= o_port_next;
        o_num_reg     <= o_num_next;
        o_phase_reg   <= o_phase_next;
        o_own_reg     <= o_own_next;
        o_total_reg   <= o_total_next;
    end

    assign m_tvalid        = out_valid_reg;
    assign out_send_valid  = o_valid_reg;
    assign out_send_kind   = o_kind_reg;
    assign out_send_port   = o_port_reg;
    assign out_send_number = o_num_reg;
    assign out_phase_now   = o_phase_reg;
    assign out_own_number  = o_own_reg;
    assign out_node_total  = o_total_reg;

    // Failed is sticky.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == mde_pkg::PH_FAILED |=> phase_reg == mde_pkg::PH_FAILED)
        else $error("left failed phase");

    // Done is sticky.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == mde_pkg::PH_DONE |=> phase_reg == mde_pkg::PH_DONE)
        else $error("left done phase");

    // The scan pointer never runs beyond one past the last port.
    assert property (@(posedge clk) disable iff (!rst_n)
        CW'(scan_reg) <= CW'(mde_pkg::PORTS))
        else $error("scan pointer out of range");

endmodule

// ===== hw/rtl/mesh_depth_first_enumerator.sv =====
`timescale 1ns / 1ps
// Channel   | Direction | Handshake          | Contents
// ----------+-----------+--------------------+-----------------------------------------
// s_*       | in        | s_tvalid/s_tready  | tuser: mode; tdata: face, payload, ready
// m_*       | out       | m_tvalid/m_tready  | tuser: send flag, kind; tdata: port...
// cfg_*     | in        | cfg_we (no stall)  | max_number
//
// An item is handled in steps: capture, decode, then, if needed, the port scan
// visits one port per cycle in the shared scan step, ending at the first ready port
// other than the parent or after the last one; a final step loads the output register.
// A finished item waits in the output register while the next item is accepted.
// A stalled m_tready holds that register and, once the next item is done, holds that
// item in its load step with s_tready low; rst_n clears the node to idle, root parent
// and max_number 63 at once.

module mesh_depth_first_enumerator (
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [2:0] face, [10:3] payload, [16:11] ports_ready
    input  logic [1:0]  s_tuser,   // [1:0] mode
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [2:0] send_port, [10:3] send_number,
                                   // [13:11] phase_now, [21:14] own_number,
                                   // [29:22] node_total
    output logic [2:0]  m_tuser,   // [0] send_valid, [2:1] send_kind
    // configuration
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);

    mde_pkg::cmd_t cmd;
    mde_pkg::sts_t sts;

    logic       o_send_valid;
    logic [1:0] o_send_kind;
    logic [2:0] o_send_port;
    logic [7:0] o_send_number;
    logic [2:0] o_phase_now;
    logic [7:0] o_own_number;
    logic [7:0] o_node_total;

    // Sequence the item: capture, decode, scan, load output.
    mde_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold node state, the message being built and the output register.
    mde_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_mode         (s_tuser),
        .in_face         (s_tdata[2:0]),
        .in_payload      (s_tdata[10:3]),
        .in_ports_ready  (s_tdata[16:11]),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .out_send_valid  (o_send_valid),
        .out_send_kind   (o_send_kind),
        .out_send_port   (o_send_port),
        .out_send_number (o_send_number),
        .out_phase_now   (o_phase_now),
        .out_own_number  (o_own_number),
        .out_node_total  (o_node_total)
    );

    // Pack the result, pad the top bits with zeros.
    assign m_tdata = {2'b00, o_node_total, o_own_number, o_phase_now,
                      o_send_number, o_send_port};
    assign m_tuser = {o_send_kind, o_send_valid};

endmodule
